@@ rtl/core/sprd_pkg.sv @@
// ----------------------------------------------------------------------------
// sprd_pkg
// shared types and constants of the sector pattern repeat decoder
// ----------------------------------------------------------------------------
package sprd_pkg;

	localparam int PatternDepth = 512;
	localparam int PatAw        = $clog2(PatternDepth);
	localparam int MaxOutput    = 8192;
	localparam int CntW         = $clog2(MaxOutput + 2);

	localparam logic [1:0] METH_RAW  = 2'd0;
	localparam logic [1:0] METH_PAT  = 2'd1;
	localparam logic [1:0] METH_RUN  = 2'd2;
	localparam logic [1:0] METH_UNK  = 2'd3;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_BAD    = 2'd1;
	localparam logic [1:0] ST_SIZE   = 2'd2;
	localparam logic [1:0] ST_PUSHRP = 2'd3;

	localparam logic OP_PUSH = 1'b0;
	localparam logic OP_TICK = 1'b1;

	typedef struct packed {
		logic       operation;
		logic [7:0] in_byte;
		logic       sector_start;
		logic       sector_end;
		logic [1:0] method;
		logic [2:0] size_code;
	} in_word_t;

	typedef struct packed {
		logic       byte_valid;
		logic [7:0] out_byte;
		logic       sector_done;
		logic [1:0] status;
	} out_word_t;

endpackage

@@ rtl/core/sprd_if.sv @@
// ----------------------------------------------------------------------------
// sprd_in_if / sprd_out_if
// valid/ready channels of the decoder
// ----------------------------------------------------------------------------
interface sprd_in_if;
	logic             valid;
	logic             ready;
	sprd_pkg::in_word_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface sprd_out_if;
	logic              valid;
	logic              ready;
	sprd_pkg::out_word_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ rtl/core/sprd_fifo.sv @@
// ----------------------------------------------------------------------------
// sprd_fifo
// two-entry word queue between front and back
// ----------------------------------------------------------------------------
module sprd_fifo (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  sprd_pkg::in_word_t wdata,
	output logic               full,
	input  logic               pop,
	output logic               nonempty,
	output sprd_pkg::in_word_t rdata
);
	import sprd_pkg::*;

	in_word_t   mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;

	assign full     = cnt_q[1];
	assign nonempty = cnt_q != 2'd0;
	assign rdata    = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule

@@ rtl/core/sprd_back.sv @@
// ----------------------------------------------------------------------------
// sprd_back
// record parser, pattern store and status; unless the output stalls, one word per cycle
// ----------------------------------------------------------------------------
module sprd_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wvalid,
	input  sprd_pkg::in_word_t  w,
	output logic                take,
	output logic                ovalid,
	output sprd_pkg::out_word_t oword,
	input  logic                oready
);
	import sprd_pkg::*;

	typedef enum logic [2:0] {
		PH_IDLE, PH_RAW, PH_FA, PH_FB, PH_BODY, PH_REP
	} phase_t;

	phase_t          phase_q;
	logic [1:0]      mode_q;
	logic [2:0]      size_q;
	logic [8:0]      blen_q;
	logic [15:0]     rcnt_q;
	logic [8:0]      lit_q;
	logic [16:0]     rleft_q;
	logic [8:0]      pidx_q;
	logic [CntW-1:0] nout_q;
	logic [1:0]      err_q;
	logic            endp_q;
	logic [7:0]      store [PatternDepth];
	// registered read of the store at the next pattern index
	logic [7:0]      rd_q;

	// repeat length: 9 x 8 bit multiply in run mode, shift in pattern mode (combinational)
	logic [16:0] rep_len;

	// output register
	logic        ovalid_q;
	out_word_t   oword_q;
	assign ovalid = ovalid_q;
	assign oword  = oword_q;
	assign take   = wvalid && (!ovalid_q || oready);

	// combinational next state
	phase_t          ph_n;
	logic [1:0]      mode_n, err_n;
	logic [2:0]      size_n;
	logic [8:0]      blen_n, lit_n, pidx_n;
	logic [15:0]     rcnt_n;
	logic [16:0]     rleft_n;
	logic [CntW-1:0] nout_n;
	logic            endp_n, emit, done, wr;
	logic [7:0]      ob;
	logic [1:0]      st;
	logic [14:0]     expect_sz;
	logic [15:0]     cnt16;

	always_comb begin
		ph_n = phase_q; mode_n = mode_q; size_n = size_q; blen_n = blen_q;
		rcnt_n = rcnt_q; lit_n = lit_q; rleft_n = rleft_q; pidx_n = pidx_q;
		nout_n = nout_q; err_n = err_q; endp_n = endp_q;
		emit = 1'b0; done = 1'b0; wr = 1'b0; ob = w.in_byte; st = ST_OK;
		rep_len = 17'd0; expect_sz = 15'd0; cnt16 = 16'd0;
		if (w.operation == OP_TICK) begin
			if (phase_q == PH_REP && rleft_q != 17'd0) begin
				emit = 1'b1;
				ob   = rd_q;
				pidx_n = (pidx_q + 9'd1 >= blen_q) ? 9'd0 : pidx_q + 9'd1;
				rleft_n = rleft_q - 17'd1;
				if (rleft_n == 17'd0) begin
					ph_n = PH_FA;
					done = endp_q;
				end
			end
		end else begin
			if (w.sector_start) begin
				mode_n = w.method; size_n = w.size_code; err_n = ST_OK;
				nout_n = '0; endp_n = 1'b0; rleft_n = '0; lit_n = '0;
				pidx_n = '0; blen_n = '0; rcnt_n = '0;
				if (w.method == METH_PAT || w.method == METH_RUN) ph_n = PH_FA;
				else begin
					if (w.method == METH_UNK) err_n = ST_BAD;
					ph_n = PH_RAW;
				end
			end
			case (ph_n)
				PH_IDLE: ;
				PH_REP: begin
					if (err_n == ST_OK) err_n = ST_PUSHRP;
					if (w.sector_end) endp_n = 1'b1;
				end
				PH_RAW: emit = 1'b1;
				PH_FA: begin
					if (mode_n == METH_PAT) rcnt_n = {8'd0, w.in_byte};
					else blen_n = {w.in_byte, 1'b0};
					ph_n = PH_FB;
				end
				PH_FB: begin
					if (mode_n == METH_PAT) begin
						cnt16 = {w.in_byte, rcnt_n[7:0]};
						if (cnt16 == 16'd0 && err_n == ST_OK) err_n = ST_BAD;
						lit_n = 9'd2; blen_n = 9'd2; rcnt_n = cnt16;
						pidx_n = '0; ph_n = PH_BODY;
					end else begin
						if (w.in_byte == 8'd0 && err_n == ST_OK) err_n = ST_BAD;
						if (blen_n == 9'd0) begin
							lit_n = {1'b0, w.in_byte}; rcnt_n = {8'd0, w.in_byte};
							ph_n = (w.in_byte != 8'd0) ? PH_BODY : PH_FA;
						end else begin
							lit_n = blen_n; rcnt_n = {8'd0, w.in_byte};
							pidx_n = '0; ph_n = PH_BODY;
						end
					end
				end
				PH_BODY: begin
					emit = 1'b1;
					if (blen_n != 9'd0) begin
						wr = 1'b1;
						pidx_n = pidx_n + 9'd1;
					end
					if (lit_n != 9'd0) lit_n = lit_n - 9'd1;
					if (lit_n == 9'd0) begin
						if (blen_n != 9'd0 && rcnt_n > 16'd1) begin
							// pattern mode count is 16 bits; run mode blen <= 510
							rep_len = (mode_n == METH_PAT)
								? {rcnt_n - 16'd1, 1'b0}
								: 17'(blen_n) * 17'(rcnt_n[7:0] - 8'd1);
							rleft_n = rep_len; pidx_n = '0; ph_n = PH_REP;
						end else ph_n = PH_FA;
					end
				end
				default: ;
			endcase
			// end of sector waits for pending repeats to drain
			if (w.sector_end && ph_n != PH_IDLE) begin
				if (ph_n == PH_REP) endp_n = 1'b1;
				else done = 1'b1;
			end
		end
		if (emit && nout_n <= CntW'(MaxOutput)) nout_n = nout_n + 1'b1;
		expect_sz = 15'd128 << size_n;
		if (err_n != ST_OK) st = err_n;
		else if (ph_n != PH_RAW && ph_n != PH_FA) st = ST_BAD;
		else if ({1'b0, nout_n} != 15'(expect_sz) || size_n == 3'd7) st = ST_SIZE;
		if (done) begin
			ph_n = PH_IDLE; endp_n = 1'b0; rleft_n = '0;
		end
	end

	// a push with no active sector and not starting one is dropped silently
	logic pushed_live;
	assign pushed_live = w.operation == OP_PUSH
		&& (w.sector_start || (phase_q != PH_IDLE && phase_q != PH_REP));

	always_ff @(posedge clk) begin
		if (take && wr) store[pidx_q[PatAw-1:0] & '1] <= w.in_byte;
		if (take) rd_q <= store[pidx_n];
		if (take) begin
			oword_q.byte_valid  <= emit;
			oword_q.out_byte    <= emit ? ob : 8'd0;
			oword_q.sector_done <= done;
			oword_q.status      <= done ? st : ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE; mode_q <= '0; size_q <= '0; blen_q <= '0;
			rcnt_q <= '0; lit_q <= '0; rleft_q <= '0; pidx_q <= '0;
			nout_q <= '0; err_q <= '0; endp_q <= 1'b0; ovalid_q <= 1'b0;
		end else begin
			if (take) begin
				phase_q <= ph_n; mode_q <= mode_n; size_q <= size_n;
				blen_q <= blen_n; rcnt_q <= rcnt_n; lit_q <= lit_n;
				rleft_q <= rleft_n; pidx_q <= pidx_n; nout_q <= nout_n;
				err_q <= err_n; endp_q <= endp_n;
				ovalid_q <= (emit || done) && (pushed_live || w.operation == OP_TICK);
			end else if (oready) ovalid_q <= 1'b0;
		end
	end
endmodule

@@ rtl/core/sector_pattern_repeat_decoder_unit.sv @@
// ----------------------------------------------------------------------------
// sector_pattern_repeat_decoder_unit
// expands packed sector data: raw, two-byte pattern entries or run records
// ----------------------------------------------------------------------------
// path: an accepted word passes the queue, then the back-end parser and its output register
// throughput: one word per cycle while the output is not stalled, set by the back-end parser
// the pattern store is one 512 x 8 memory, at most one write and one registered read per word
// reset: arst_n clears queue, parser phase, counters and output valid at once
module sector_pattern_repeat_decoder_unit (
	input logic        clk,
	input logic        arst_n,
	sprd_in_if.sink    in_ch,
	sprd_out_if.source out_ch
);
	import sprd_pkg::*;

	// front: accept words into the queue whenever it has room
	logic     full, nonempty, take;
	in_word_t qword;

	assign in_ch.ready = !full;

	sprd_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (in_ch.valid && !full),
		.wdata    (in_ch.data),
		.full     (full),
		.pop      (take),
		.nonempty (nonempty),
		.rdata    (qword)
	);

	// back: parse one word per cycle while the output register can move
	sprd_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.wvalid (nonempty),
		.w      (qword),
		.take   (take),
		.ovalid (out_ch.valid),
		.oword  (out_ch.data),
		.oready (out_ch.ready)
	);
endmodule

@@ rtl/core/sprd_checker.sv @@
// ----------------------------------------------------------------------------
// sprd_checker
// port-level checks of the decoder
// ----------------------------------------------------------------------------
module sprd_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                out_valid,
	input logic                out_ready,
	input sprd_pkg::out_word_t out_data
);
	import sprd_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("output word changed while stalled");

	a_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.byte_valid || out_data.sector_done)
		else $error("empty result word");

	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.sector_done |-> out_data.status == ST_OK)
		else $error("status without sector end");

	a_byte: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.byte_valid |-> out_data.out_byte == 8'd0)
		else $error("byte without valid");
endmodule

bind sector_pattern_repeat_decoder_unit sprd_checker u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.out_data  (out_ch.data)
);

@@ tb/sprd_tb_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sprd testbench channel notes
// the decoder channels come from the rtl interface file; this file holds the
// testbench word types used by the scoreboard
// ----------------------------------------------------------------------------
package sprd_tb_pkg;
	import sprd_pkg::*;

	typedef struct {
		logic       byte_valid;
		logic [7:0] out_byte;
		logic       sector_done;
		logic [1:0] status;
	} dec_word_t;
endpackage

@@ tb/tb_sector_pattern_repeat_decoder_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sector_pattern_repeat_decoder_unit
// drives packed sector words through the decoder, predicts every decoded
// word and checks the output stream in order under random idling and stalls
// ----------------------------------------------------------------------------
module tb_sector_pattern_repeat_decoder_unit;
	import sprd_pkg::*;
	import sprd_tb_pkg::*;

	localparam int PH_IDLE = 0, PH_RAW = 1, PH_FA = 2, PH_FB = 3, PH_BODY = 4, PH_REP = 5;

	logic clk;
	logic arst_n;
	int   n_fail;
	int   cycles;
	int   send_idle_pct;
	int   recv_stall_pct;
	bit   hold_off;
	int   n_items;
	int   n_done;

	sprd_in_if  in_ch ();
	sprd_out_if out_ch ();

	sector_pattern_repeat_decoder_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch.sink),
		.out_ch (out_ch.source)
	);

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		n_fail++;
	endtask

	// decoder shadow and queue of predicted words
	class sector_scoreboard;
		logic [1:0]  mode;
		logic [2:0]  size_code;
		int          phase;
		logic [8:0]  block_len;
		logic [15:0] rep_cnt;
		logic [8:0]  lit_left;
		logic [16:0] rep_left;
		logic [7:0]  pat_mem [PatternDepth];
		logic [8:0]  pat_idx;
		logic [13:0] n_out;
		logic [1:0]  err;
		bit          end_pend;
		dec_word_t   pending [$];

		function new();
			mode = 0; size_code = 0; phase = PH_IDLE; block_len = 0; rep_cnt = 0;
			lit_left = 0; rep_left = 0; pat_idx = 0; n_out = 0; err = 0; end_pend = 0;
		endfunction

		function void latch(logic [1:0] c);
			if (err == ST_OK) err = c;
		endfunction

		function void bump();
			if (n_out < MaxOutput + 1) n_out++;
		endfunction

		function logic [1:0] sector_status();
			if (err != ST_OK) return err;
			if (phase != PH_RAW && phase != PH_FA) return ST_BAD;
			if (32'(n_out) != (32'd128 << size_code)) return ST_SIZE;
			return ST_OK;
		endfunction

		function void close_out(ref dec_word_t w);
			w.sector_done = 1;
			w.status = sector_status();
			phase = PH_IDLE;
			end_pend = 0;
			rep_left = 0;
		endfunction

		function void open_body(logic [8:0] len, logic [15:0] cnt);
			lit_left = len; block_len = len; rep_cnt = cnt; pat_idx = 0; phase = PH_BODY;
		endfunction

		// note one accepted input word
		function void note_input(in_word_t x);
			dec_word_t w;
			logic [15:0] cnt;
			w = '{0, 8'd0, 0, ST_OK};
			if (x.operation == OP_TICK) begin
				if (phase != PH_REP || rep_left == 0) return;
				w.byte_valid = 1;
				w.out_byte = pat_mem[pat_idx];
				bump();
				pat_idx++;
				if (pat_idx >= block_len) pat_idx = 0;
				rep_left--;
				if (rep_left == 0) begin
					phase = PH_FA;
					if (end_pend) close_out(w);
				end
				pending.push_back(w);
				return;
			end
			if (x.sector_start) begin
				mode = x.method; size_code = x.size_code; err = 0; n_out = 0;
				end_pend = 0; rep_left = 0; lit_left = 0; pat_idx = 0;
				block_len = 0; rep_cnt = 0;
				if (x.method == METH_PAT || x.method == METH_RUN) phase = PH_FA;
				else begin
					if (x.method == METH_UNK) latch(ST_BAD);
					phase = PH_RAW;
				end
			end
			if (phase == PH_IDLE) return;
			if (phase == PH_REP) begin
				latch(ST_PUSHRP);
				if (x.sector_end) end_pend = 1;
				return;
			end
			case (phase)
				PH_RAW: begin
					w.byte_valid = 1; w.out_byte = x.in_byte; bump();
				end
				PH_FA: begin
					if (mode == METH_PAT) rep_cnt = {8'd0, x.in_byte};
					else block_len = {x.in_byte, 1'b0};
					phase = PH_FB;
				end
				PH_FB: begin
					if (mode == METH_PAT) begin
						cnt = {x.in_byte, rep_cnt[7:0]};
						if (cnt == 0) latch(ST_BAD);
						open_body(9'd2, cnt);
					end else begin
						if (x.in_byte == 0) latch(ST_BAD);
						if (block_len == 0) begin
							lit_left = {1'b0, x.in_byte};
							rep_cnt = {8'd0, x.in_byte};
							phase = (x.in_byte != 0) ? PH_BODY : PH_FA;
						end else open_body(block_len, {8'd0, x.in_byte});
					end
				end
				default: begin
					w.byte_valid = 1; w.out_byte = x.in_byte; bump();
					if (block_len != 0) begin
						pat_mem[pat_idx] = x.in_byte;
						pat_idx++;
					end
					if (lit_left > 0) lit_left--;
					if (lit_left == 0) begin
						if (block_len != 0 && rep_cnt > 1) begin
							rep_left = 17'(block_len) * 17'(rep_cnt - 16'd1);
							pat_idx = 0;
							phase = PH_REP;
						end else phase = PH_FA;
					end
				end
			endcase
			if (x.sector_end) begin
				if (phase == PH_REP) end_pend = 1;
				else close_out(w);
			end
			if (w.byte_valid || w.sector_done) pending.push_back(w);
		endfunction

		// check one accepted output word against the oldest prediction
		task check_output(out_word_t y);
			dec_word_t w;
			if (pending.size() == 0) begin
				report_mismatch("unexpected word", y, -1);
				return;
			end
			w = pending.pop_front();
			if (y.byte_valid !== w.byte_valid) report_mismatch("byte_valid", y.byte_valid, w.byte_valid);
			if (y.out_byte !== w.out_byte) report_mismatch("out_byte", y.out_byte, w.out_byte);
			if (y.sector_done !== w.sector_done)
				report_mismatch("sector_done", y.sector_done, w.sector_done);
			if (y.status !== w.status) report_mismatch("status", y.status, w.status);
		endtask
	endclass

	sector_scoreboard sb;

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > 400000) begin
				$display("timeout after %0d cycles", cycles);
				$display("tb_sector_pattern_repeat_decoder_unit: FAIL");
				$finish;
			end
		end
	end

	// receiver: random stalls, plus long hold-off when asked
	initial begin
		out_ch.ready = 0;
		forever begin
			@(posedge clk);
			if (arst_n && out_ch.valid && out_ch.ready) begin
				sb.check_output(out_ch.data);
				if (out_ch.data.sector_done) n_done++;
			end
			out_ch.ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// send one word, idling at random beforehand; valid stays up until the next
	// idle cycle or drain
	task automatic send_word(input in_word_t x);
		while ($urandom_range(99) < send_idle_pct) begin
			in_ch.valid <= 0;
			@(posedge clk);
		end
		in_ch.valid <= 1;
		in_ch.data <= x;
		do @(posedge clk); while (!in_ch.ready);
		sb.note_input(x);
		n_items++;
	endtask

	task automatic push_byte(input logic [7:0] b, input bit st = 0, input bit en = 0,
			input logic [1:0] m = METH_RAW, input logic [2:0] sz = 0);
		in_word_t x;
		x.operation = OP_PUSH; x.in_byte = b; x.sector_start = st; x.sector_end = en;
		x.method = m; x.size_code = sz;
		send_word(x);
	endtask

	task automatic tick();
		in_word_t x;
		x = in_word_t'($urandom);
		x.operation = OP_TICK;
		send_word(x);
	endtask

	// a sector of the given method with random content; zero counts and method 3 make it malformed
	task automatic random_sector(input logic [1:0] m);
		int n, k, len, cnt;
		logic [2:0] sz;
		sz = $urandom_range(1) ? 3'd0 : 3'($urandom_range(7));
		n = $urandom_range(1, 4);
		if (m == METH_RAW || m == METH_UNK) begin
			len = $urandom_range(1, 10);
			for (k = 0; k < len; k++) push_byte(8'($urandom), k == 0, k == len - 1, m, sz);
			return;
		end
		// the first field byte of the first record opens the sector
		for (int r = 0; r < n; r++) begin
			bit last;
			last = (r == n - 1);
			if (m == METH_PAT) begin
				cnt = $urandom_range(9) == 0 ? 0 : $urandom_range(1, 6);
				if (r == 0) push_byte(cnt[7:0], 1, 0, m, sz);
				else push_byte(cnt[7:0]);
				push_byte(8'd0);
				push_byte(8'($urandom)); push_byte(8'($urandom), 0, last && cnt <= 1);
				for (k = 0; k < 2 * (cnt - 1); k++) tick();
				if (last && cnt > 1) push_byte(8'($urandom), 0, 1);
			end else begin
				len = $urandom_range(3) == 0 ? 0 : $urandom_range(1, 3);
				cnt = $urandom_range(12) == 0 ? 0 : $urandom_range(1, 4);
				if (r == 0) push_byte(len[7:0], 1, 0, m, sz);
				else push_byte(len[7:0]);
				push_byte(cnt[7:0], 0, last && cnt == 0);
				if (cnt == 0) continue;
				k = (len == 0) ? cnt : 2 * len;
				for (int j = 0; j < k; j++) push_byte(8'($urandom), 0, last && j == k - 1);
				if (len > 0)
					for (k = 0; k < 2 * len * (cnt - 1); k++) tick();
			end
		end
	endtask

	task automatic noise();
		in_word_t x;
		x = in_word_t'($urandom);
		if (x.method == METH_UNK && $urandom_range(1)) x.method = METH_RAW;
		send_word(x);
	endtask

	task automatic wait_drain();
		in_ch.valid <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	initial begin
		int ph, budget;
		sb = new();
		n_fail = 0; n_items = 0; n_done = 0;
		send_idle_pct = 0; recv_stall_pct = 0; hold_off = 0;
		in_ch.valid = 0;
		in_ch.data = '0;
		arst_n = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: raw extremes, size mismatch, methods, errors
		push_byte(8'h00, 1, 0, METH_RAW, 3'd7);
		push_byte(8'hff, 0, 1);
		push_byte(8'h5a); // outside a sector, ignored
		tick(); // nothing pending
		push_byte(8'd3, 1, 0, METH_PAT, 3'd0); // pattern count 3
		push_byte(8'd0); push_byte(8'haa); push_byte(8'h55);
		push_byte(8'h11); // push during repeats
		push_byte(8'h22, 0, 1); // end deferred
		repeat (4) tick();
		push_byte(8'd0, 1, 0, METH_PAT); push_byte(8'd0); // zero count
		push_byte(8'h01); push_byte(8'h02, 0, 1);
		push_byte(8'd0, 1, 0, METH_RUN); push_byte(8'd2); // literal run
		push_byte(8'h80); push_byte(8'h7f);
		push_byte(8'd1); push_byte(8'd2); push_byte(8'h0f); push_byte(8'hf0);
		tick(); push_byte(8'd9, 1, 0, METH_UNK, 3'd6); // abandons repeats, method 3
		push_byte(8'd1, 0, 1);
		push_byte(8'd4, 1, 0, METH_RUN); push_byte(8'd0, 0, 1); // truncated
		wait_drain();

		// long hold-off so the decoder fills and stalls its input
		hold_off = 1;
		fork
			begin
				repeat (60) @(posedge clk);
				hold_off = 0;
			end
			begin
				for (int k = 0; k < 30; k++)
					push_byte(8'($urandom), k == 0, k == 29, METH_RAW, 3'd0);
				in_ch.valid <= 0;
			end
		join
		wait_drain();

		for (ph = 0; ph < 4; ph++) begin
			send_idle_pct  = (ph == 1) ? 50 : (ph == 3) ? 27 : 0;
			recv_stall_pct = (ph == 2) ? 50 : (ph == 3) ? 27 : 0;
			budget = n_items + 150;
			while (n_items < budget) begin
				case ($urandom_range(9))
					0: noise();
					1: random_sector(METH_RAW);
					2: random_sector(METH_UNK);
					3, 4, 5: random_sector(METH_PAT);
					default: random_sector(METH_RUN);
				endcase
			end
			wait_drain();
		end

		$display("covered %0d input words and %0d finished sectors across four idling phases",
			n_items, n_done);
		if (n_fail == 0) begin
			$display("tb_sector_pattern_repeat_decoder_unit: PASS");
		end else begin
			$display("tb_sector_pattern_repeat_decoder_unit: FAIL");
		end
		$finish;
	end
endmodule
